// ===== sv/sbr_pkg.sv =====
// Package: shared constants, operation and status codes, circular slot arithmetic.
package sbr_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [WORD_WIDTH-1:0] word_t;

    typedef enum logic [2:0] {
        MODE_PUSH   = 3'd0,
        MODE_POP    = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_PEEK   = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic    mem_we;
        logic    mem_re;
        ptr_t    mem_addr;
        status_t status;
        cnt_t    count_next;
        ptr_t    bottom_next;
    } op_ctrl_t;

    // Wrap bottom + offset into the circular store.
    function automatic ptr_t slot(input ptr_t bottom, input cnt_t offset);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(bottom) + (CNT_W + 1)'(offset);
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return PTR_W'(sum);
    endfunction

endpackage

// ===== sv/sbr_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module sbr_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sbr_decode.sv =====
// Operation decode: store access, status and next pointer and count.
module sbr_decode (
    input  logic [2:0]      mode,
    input  logic [6:0]      peek_position,
    input  sbr_pkg::ptr_t   bottom,
    input  sbr_pkg::cnt_t   count,
    output sbr_pkg::op_ctrl_t ctrl
);

    logic          empty;
    logic          full;
    logic          pos_out;
    sbr_pkg::cnt_t top_off;
    sbr_pkg::cnt_t pos_off;

    assign empty   = (count == '0);
    assign full    = (count == sbr_pkg::CNT_W'(sbr_pkg::DEPTH));
    assign top_off = count - sbr_pkg::CNT_W'(1);
    assign pos_off = sbr_pkg::CNT_W'(peek_position[5:0]);
    assign pos_out = (32'(peek_position[5:0]) >= 32'(count));

    always_comb
    begin
        ctrl.mem_we      = 1'b0;
        ctrl.mem_re      = 1'b0;
        ctrl.mem_addr    = sbr_pkg::slot(bottom, top_off);
        ctrl.status      = sbr_pkg::ST_OK;
        ctrl.count_next  = count;
        ctrl.bottom_next = bottom;
        unique case (mode)
            sbr_pkg::MODE_PUSH:
            begin
                ctrl.mem_addr = sbr_pkg::slot(bottom, count);
                if (full)
                begin
                    ctrl.status = sbr_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.mem_we     = 1'b1;
                    ctrl.count_next = count + sbr_pkg::CNT_W'(1);
                end
            end
            sbr_pkg::MODE_POP:
            begin
                if (empty)
                begin
                    ctrl.status = sbr_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.mem_re     = 1'b1;
                    ctrl.count_next = top_off;
                end
            end
            sbr_pkg::MODE_REMOVE:
            begin
                ctrl.mem_addr = bottom;
                if (empty)
                begin
                    ctrl.status = sbr_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.mem_re      = 1'b1;
                    ctrl.count_next  = top_off;
                    ctrl.bottom_next = sbr_pkg::slot(bottom, sbr_pkg::CNT_W'(1));
                end
            end
            sbr_pkg::MODE_PEEK:
            begin
                if (empty)
                begin
                    ctrl.status = sbr_pkg::ST_EMPTY;
                end
                else if (peek_position[6])
                begin
                    ctrl.mem_re = 1'b1;
                end
                else if (pos_out)
                begin
                    ctrl.status = sbr_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.mem_re   = 1'b1;
                    ctrl.mem_addr = sbr_pkg::slot(bottom, pos_off);
                end
            end
            sbr_pkg::MODE_CLEAR:
            begin
                ctrl.count_next  = '0;
                ctrl.bottom_next = '0;
            end
            default:
            begin
                ctrl.status = sbr_pkg::ST_OK;
            end
        endcase
    end

endmodule

// ===== sv/stack_with_bottom_removal_unit.sv =====
// Top level: bounded word stack with bottom removal and indexed peek.
//
//  channel   | handshake       | payload
//  ----------+-----------------+-----------------------------------------
//  command   | start / busy    | mode, push_word, peek_position
//  result    | done (strobe)   | result_word, status, entry_count
//
// One operation per cycle: the store access is issued at the accepting edge,
// and the result strobe follows in the next cycle with the registered read data.
// busy stays low; every operation makes at most one access to the one-port store.
// Reset clears the bottom pointer and entry count; the store is not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
module stack_with_bottom_removal_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [31:0] push_word,
    input  logic [6:0]  peek_position,
    output logic        done,
    output logic [31:0] result_word,
    output logic [1:0]  status,
    output logic [6:0]  entry_count
);

    logic              accept;
    sbr_pkg::op_ctrl_t ctrl;
    sbr_pkg::word_t    rdata;

    sbr_pkg::ptr_t     bottom_reg;
    sbr_pkg::cnt_t     count_reg;
    logic              done_reg;
    logic              rd_reg;
    sbr_pkg::status_t  status_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    sbr_decode u_decode (
        .mode          (mode),
        .peek_position (peek_position),
        .bottom        (bottom_reg),
        .count         (count_reg),
        .ctrl          (ctrl)
    );

    sbr_ram #(
        .WIDTH  (sbr_pkg::WORD_WIDTH),
        .DEPTH  (sbr_pkg::DEPTH),
        .ADDR_W (sbr_pkg::PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (accept && ctrl.mem_we),
        .re    (accept && ctrl.mem_re),
        .addr  (ctrl.mem_addr),
        .wdata (sbr_pkg::WORD_WIDTH'(push_word)),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottom_reg <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            rd_reg     <= 1'b0;
            status_reg <= sbr_pkg::ST_OK;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                bottom_reg <= ctrl.bottom_next;
                count_reg  <= ctrl.count_next;
                rd_reg     <= ctrl.mem_re;
                status_reg <= ctrl.status;
            end
        end
    end

    assign done        = done_reg;
    assign result_word = rd_reg ? 32'(rdata) : 32'd0;
    assign status      = status_reg;
    assign entry_count = 7'(count_reg);

endmodule

// ===== sv/sbr_check.sv =====
// Port checker for the stack unit, bound to the top level.
module sbr_check (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  mode,
    input logic        done,
    input logic [31:0] result_word,
    input logic [1:0]  status,
    input logic [6:0]  entry_count
);

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted transaction without result strobe");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result strobe without transaction");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != sbr_pkg::ST_OK) |-> (result_word == 32'd0))
        else $error("failed operation returned non-zero word");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == sbr_pkg::ST_FULL) |->
        (32'(entry_count) == sbr_pkg::DEPTH))
        else $error("push rejected while not full");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == sbr_pkg::ST_OK && $past(mode) == sbr_pkg::MODE_PUSH)
        |-> (entry_count != 7'd0))
        else $error("successful push left the stack empty");

endmodule

bind stack_with_bottom_removal_unit sbr_check u_sbr_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .done        (done),
    .result_word (result_word),
    .status      (status),
    .entry_count (entry_count)
);

// ===== tb/stack_with_bottom_removal_unit_tb.sv =====
// Testbench for the bounded word stack: queued command driver, predictor and result checker.
module stack_with_bottom_removal_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbr_pkg::*;

    localparam logic [2:0] MODE_SPARE_A = 3'd5;
    localparam logic [2:0] MODE_SPARE_B = 3'd6;
    localparam logic [2:0] MODE_SPARE_C = 3'd7;
    localparam logic [6:0] PEEK_TOP     = 7'h7F;
    localparam logic [6:0] PEEK_MOST_NEG = 7'h40;
    localparam int         RANDOM_OPS   = 650;

    typedef struct {
        logic [2:0]  op;
        word_t       word;
        logic [6:0]  pos;
        bit          pause;
    } stack_cmd_t;

    typedef struct {
        word_t       word;
        status_t     st;
        logic [6:0]  cnt;
    } stack_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  mode = MODE_PUSH;
    logic [31:0] push_word = '0;
    logic [6:0]  peek_position = '0;
    logic        done;
    logic [31:0] result_word;
    logic [1:0]  status;
    logic [6:0]  entry_count;

    stack_cmd_t   pending_ops[$];
    stack_reply_t expected_replies[$];
    logic         drained = 1'b1;
    logic         pausing = 1'b0;
    int unsigned  cyc = 0;
    int           mismatch_count = 0;

    word_t        model_mem [DEPTH];
    int unsigned  model_base = 0;
    int unsigned  model_held = 0;

    int           plan_count = 0;
    int           op_total = 0;

    stack_with_bottom_removal_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .push_word     (push_word),
        .peek_position (peek_position),
        .done          (done),
        .result_word   (result_word),
        .status        (status),
        .entry_count   (entry_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic stack_reply_t apply_stack_op(input logic [2:0] op, input word_t word,
                                                    input logic [6:0] pos);
        stack_reply_t r;
        r.word = '0;
        r.st   = ST_OK;
        case (op)
            MODE_PUSH:
            begin
                if (model_held >= DEPTH)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    model_mem[PTR_W'((model_base + model_held) % DEPTH)] = word;
                    model_held++;
                end
            end
            MODE_POP:
            begin
                if (model_held == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else
                begin
                    r.word = model_mem[PTR_W'((model_base + model_held - 1) % DEPTH)];
                    model_held--;
                end
            end
            MODE_REMOVE:
            begin
                if (model_held == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else
                begin
                    r.word     = model_mem[PTR_W'(model_base)];
                    model_base = (model_base + 1) % DEPTH;
                    model_held--;
                end
            end
            MODE_PEEK:
            begin
                if (model_held == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else if (pos[6])
                begin
                    r.word = model_mem[PTR_W'((model_base + model_held - 1) % DEPTH)];
                end
                else if (int'(pos) >= model_held)
                begin
                    r.st = ST_EMPTY;
                end
                else
                begin
                    r.word = model_mem[PTR_W'((model_base + int'(pos)) % DEPTH)];
                end
            end
            MODE_CLEAR:
            begin
                model_held = 0;
                model_base = 0;
            end
            default:
            begin
            end
        endcase
        r.cnt = 7'(model_held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        stack_cmd_t cmd;
        logic       quiet;
        if (!rst_n)
        begin
            start         <= 1'b0;
            mode          <= MODE_PUSH;
            push_word     <= '0;
            peek_position <= '0;
            pausing       <= 1'b0;
            cyc           <= 0;
        end
        else
        begin
            cyc   <= cyc + 1;
            quiet = (cyc >= 400 && cyc < 1000);
            if (start && busy)
            begin
            end
            else if (pausing)
            begin
                start <= 1'b0;
                if (drained && !start)
                begin
                    pausing <= 1'b0;
                end
            end
            else if (pending_ops.size() != 0 && pending_ops[0].pause)
            begin
                cmd = pending_ops.pop_front();
                pausing <= 1'b1;
                start   <= 1'b0;
            end
            else if (pending_ops.size() != 0 && (quiet || $urandom_range(0, 99) >= 9))
            begin
                cmd = pending_ops.pop_front();
                start         <= 1'b1;
                mode          <= cmd.op;
                push_word     <= cmd.word;
                peek_position <= cmd.pos;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_blk
        stack_reply_t want;
        if (!rst_n)
        begin
            drained <= 1'b1;
        end
        else
        begin
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected transaction: word %h status %0d count %0d",
                             $time, result_word, status, entry_count);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (result_word !== want.word)
                    begin
                        $display("%0t: result_word expected %h, got %h",
                                 $time, want.word, result_word);
                        mismatch_count++;
                    end
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d, got %0d", $time, want.st, status);
                        mismatch_count++;
                    end
                    if (entry_count !== want.cnt)
                    begin
                        $display("%0t: entry_count expected %0d, got %0d",
                                 $time, want.cnt, entry_count);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_replies.push_back(apply_stack_op(mode, push_word, peek_position));
            end
            drained <= (expected_replies.size() == 0);
        end
    end

    task automatic queue_op(input logic [2:0] op, input word_t word, input logic [6:0] pos);
        stack_cmd_t c;
        c.op    = op;
        c.word  = word;
        c.pos   = pos;
        c.pause = 1'b0;
        pending_ops.push_back(c);
        case (op)
            MODE_PUSH:
            begin
                if (plan_count < DEPTH)
                begin
                    plan_count++;
                end
            end
            MODE_POP, MODE_REMOVE:
            begin
                if (plan_count > 0)
                begin
                    plan_count--;
                end
            end
            MODE_CLEAR:
            begin
                plan_count = 0;
            end
            default:
            begin
            end
        endcase
        if (op <= MODE_CLEAR)
        begin
            op_total++;
        end
    endtask

    task automatic queue_pause();
        stack_cmd_t c;
        c.op    = MODE_PUSH;
        c.word  = '0;
        c.pos   = '0;
        c.pause = 1'b1;
        pending_ops.push_back(c);
    endtask

    task automatic queue_random_op();
        int         roll;
        logic [6:0] pos;
        roll = $urandom_range(0, 99);
        pos  = 7'($urandom_range(0, 127));
        if (plan_count != 0 && $urandom_range(0, 3) != 0)
        begin
            pos = 7'($urandom_range(0, plan_count - 1));
        end
        if (roll < 38)
        begin
            queue_op(MODE_PUSH, $urandom, pos);
        end
        else if (roll < 53)
        begin
            queue_op(MODE_POP, $urandom, pos);
        end
        else if (roll < 68)
        begin
            queue_op(MODE_REMOVE, $urandom, pos);
        end
        else if (roll < 93)
        begin
            queue_op(MODE_PEEK, $urandom, pos);
        end
        else if (roll < 96)
        begin
            queue_op(MODE_CLEAR, $urandom, pos);
        end
        else
        begin
            queue_op(3'($urandom_range(MODE_SPARE_A, MODE_SPARE_C)), $urandom, pos);
        end
    endtask

    initial
    begin
        int directed_total;
        int kind;

        queue_op(MODE_POP, 32'h1234_5678, 7'd0);
        queue_op(MODE_REMOVE, '1, 7'd0);
        queue_op(MODE_PEEK, '0, 7'd0);
        queue_op(MODE_PEEK, '0, PEEK_TOP);
        queue_op(MODE_PUSH, 32'h0000_0000, 7'd0);
        queue_op(MODE_PUSH, 32'hFFFF_FFFF, PEEK_TOP);
        queue_op(MODE_PUSH, 32'hA5A5_5A5A, 7'd63);
        queue_op(MODE_PEEK, '0, PEEK_TOP);
        queue_op(MODE_PEEK, '0, 7'd0);
        queue_op(MODE_PEEK, '0, 7'd2);
        queue_op(MODE_PEEK, '0, 7'd3);
        queue_op(MODE_PEEK, '0, 7'd63);
        queue_op(MODE_PEEK, '0, PEEK_MOST_NEG);
        queue_op(MODE_REMOVE, '0, 7'd0);
        queue_op(MODE_PEEK, '0, 7'd0);
        queue_op(MODE_POP, '0, 7'd0);
        queue_op(MODE_SPARE_A, '1, PEEK_TOP);
        queue_op(MODE_SPARE_B, '1, 7'd1);
        queue_op(MODE_SPARE_C, '1, 7'd0);
        queue_op(MODE_CLEAR, '1, PEEK_TOP);
        queue_op(MODE_POP, '0, 7'd0);
        queue_op(MODE_PUSH, 32'h8000_0001, 7'd0);
        queue_op(MODE_CLEAR, '0, 7'd0);
        queue_pause();
        directed_total = op_total;

        while (op_total < directed_total + RANDOM_OPS)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0:
                begin
                    while (plan_count < DEPTH)
                    begin
                        queue_op(MODE_PUSH, $urandom, 7'($urandom_range(0, 127)));
                    end
                    repeat ($urandom_range(1, 3))
                    begin
                        queue_op(MODE_PUSH, $urandom, 7'($urandom_range(0, 127)));
                    end
                    queue_op(MODE_PEEK, '0, 7'(DEPTH - 1));
                end
                1:
                begin
                    while (plan_count > 0)
                    begin
                        queue_op($urandom_range(0, 1) ? MODE_POP : MODE_REMOVE, $urandom,
                                 7'($urandom_range(0, 127)));
                    end
                    queue_op($urandom_range(0, 1) ? MODE_POP : MODE_REMOVE, $urandom, '0);
                end
                2:
                begin
                    queue_pause();
                    repeat ($urandom_range(4, 12))
                    begin
                        queue_random_op();
                    end
                end
                default:
                begin
                    repeat ($urandom_range(6, 20))
                    begin
                        queue_random_op();
                    end
                end
            endcase
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(negedge clk);
        end
        while (pending_ops.size() != 0 || start || pausing);
        while (expected_replies.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);

        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sbr_pkg.sv
sv/sbr_ram.sv
sv/sbr_decode.sv
sv/stack_with_bottom_removal_unit.sv
sv/sbr_check.sv
tb/stack_with_bottom_removal_unit_tb.sv
